@@ rtl/jsp_pkg.sv @@
// jsp_pkg: shared types and constants for the junction speed planner
// no dependencies
`timescale 1ns / 1ps

package jsp_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = $clog2(RING_DEPTH);

    localparam int SQRT_STEPS = 35;
    localparam int UDIV_STEPS = 15;
    localparam int JDIV_STEPS = 48;
    localparam int STEP_W     = 6;

    localparam logic signed [31:0] COS_LIMIT = 32'sd268435188;
    localparam logic signed [31:0] ONE_Q28   = 32'sd268435456;
    localparam logic [47:0]        MAX48     = {48{1'b1}};
    localparam logic [33:0]        MAX34     = {34{1'b1}};

    localparam logic [1:0] CFG_ACCEL     = 2'd0;
    localparam logic [1:0] CFG_DEVIATION = 2'd1;
    localparam logic [1:0] CFG_MIN_JCT   = 2'd2;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LEN_SQRT,
        ST_UNIT_LOAD,
        ST_UNIT_DIV,
        ST_COS,
        ST_JCT_SQRT,
        ST_AD_MUL,
        ST_JCT_DIV,
        ST_DONE
    } state_t;

endpackage

@@ rtl/junction_speed_planner.sv @@
// junction_speed_planner: junction deviation cornering speed for straight moves
// depends on jsp_pkg
`timescale 1ns / 1ps

// channel | signals                          | beat taken when
// --------+----------------------------------+--------------------------
// in      | in_valid, in_ready, target_*,    | in_valid && in_ready
//         | feed, queue_empty                |
// out     | out_valid, out_ready, slot_index,| out_valid && out_ready
//         | dir_*, path_length, speed fields |
// cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// one beat runs from accept through the multiply slots, 35 square root steps for the length,
// a load and 15 divide steps for each axis of the unit vector, the cos slots,
// 35 square root steps for the half-angle sine, the a*d*s multiply slots, 48 divide steps
// and the hand-over to the output register before the next accept when the output is free;
// zero-length moves, an empty queue, a near reversal or a saturating junction speed
// skip some of these steps.
// the square root and divider units resolve one bit a cycle.
// reset clears the sequencer and the history and loads the configuration defaults at once.
// a finished result sits in the output register; the next beat is taken while it waits.

module junction_speed_planner
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       target_x,
    input  logic signed [31:0]       target_y,
    input  logic signed [31:0]       target_z,
    input  logic [23:0]              feed,
    input  logic                     queue_empty,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [3:0]               slot_index,
    output logic [1:0]               dir_x,
    output logic [1:0]               dir_y,
    output logic [1:0]               dir_z,
    output logic [33:0]              path_length,
    output logic [47:0]              cruise_speed_sqr,
    output logic [47:0]              junction_speed_sqr,
    output logic [47:0]              entry_limit_sqr,
    output logic                     start_from_rest,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [47:0]              cfg_data
);

    import jsp_pkg::*;

    // control state and history
    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [AXIS_W-1:0]        axis_reg, axis_next;
    logic signed [31:0]       last_pos_reg [AXES];
    logic signed [31:0]       last_pos_next [AXES];
    logic signed [15:0]       last_unit_reg [AXES];
    logic signed [15:0]       last_unit_next [AXES];
    logic [47:0]              last_nom_reg, last_nom_next;
    logic [SLOT_W-1:0]        head_reg, head_next;
    logic [31:0]              accel_reg;
    logic [15:0]              dev_reg;
    logic [47:0]              min_jct_reg;
    logic                     out_valid_reg, out_valid_next;

    // datapath
    logic signed [31:0]       tgt_reg [AXES];
    logic signed [31:0]       tgt_next [AXES];
    logic [32:0]              mag_reg [AXES];
    logic [32:0]              mag_next [AXES];
    logic [1:0]               dir_reg [AXES];
    logic [1:0]               dir_next [AXES];
    logic signed [15:0]       unit_reg [AXES];
    logic signed [15:0]       unit_next [AXES];
    logic [23:0]              feed_reg, feed_next;
    logic                     empty_reg, empty_next;
    logic [65:0]              prod_reg, prod_next;
    logic [65:0]              sum_reg, sum_next;
    logic [47:0]              nom_reg, nom_next;
    logic [47:0]              ad_reg, ad_next;
    logic [34:0]              len_reg, len_next;
    logic signed [31:0]       cos_reg, cos_next;
    logic [28:0]              s_reg, s_next;
    logic [76:0]              big_reg, big_next;
    logic [47:0]              jct_reg, jct_next;

    // square root unit
    logic [69:0]              sq_in_reg, sq_in_next;
    logic [36:0]              sq_rem_reg, sq_rem_next;
    logic [34:0]              sq_root_reg, sq_root_next;
    logic [38:0]              sq_t, sq_trial;
    logic                     sq_ge;
    logic [34:0]              sq_root_step;
    logic [36:0]              sq_rem_step;

    // divider unit
    logic [34:0]              dv_rem_reg, dv_rem_next;
    logic [34:0]              dv_den_reg, dv_den_next;
    logic [47:0]              dv_num_reg, dv_num_next;
    logic [47:0]              dv_quo_reg, dv_quo_next;
    logic [35:0]              dv_t;
    logic                     dv_ge;
    logic [34:0]              dv_rem_step;
    logic [47:0]              dv_quo_step;

    // shared multiplier
    logic [32:0]              mul_a, mul_b;

    // output register
    logic [3:0]               o_slot_reg, o_slot_next;
    logic [1:0]               o_dir_reg [AXES];
    logic [1:0]               o_dir_next [AXES];
    logic [33:0]              o_len_reg, o_len_next;
    logic [47:0]              o_nom_reg, o_nom_next;
    logic [47:0]              o_jct_reg, o_jct_next;
    logic [47:0]              o_entry_reg, o_entry_next;
    logic                     o_rest_reg, o_rest_next;

    // helpers
    logic signed [31:0]       in_tgt [AXES];
    logic signed [32:0]       delta  [AXES];
    logic [AXIS_W-1:0]        idx_cur, idx_prev;
    logic [14:0]              unit_abs [AXES];
    logic [14:0]              last_abs [AXES];
    logic [46:0]              udiv_num;
    logic signed [31:0]       cos_clamped;
    logic [29:0]              jct_root_arg;
    logic [28:0]              jct_den;
    logic [47:0]              entry;
    logic [47:0]              jct_final;

    assign in_tgt[0] = target_x;
    assign in_tgt[1] = target_y;
    assign in_tgt[2] = target_z;

    assign idx_cur  = step_reg[AXIS_W-1:0];
    assign idx_prev = AXIS_W'(step_reg - STEP_W'(1));

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            delta[i]    = {in_tgt[i][31], in_tgt[i]} - {last_pos_reg[i][31], last_pos_reg[i]};
            unit_abs[i] = unit_reg[i][15] ? 15'(-unit_reg[i]) : unit_reg[i][14:0];
            last_abs[i] = last_unit_reg[i][15] ? 15'(-last_unit_reg[i]) : last_unit_reg[i][14:0];
        end
    end

    // square root step: two radicand bits in, one root bit out
    assign sq_t         = {sq_rem_reg, sq_in_reg[69:68]};
    assign sq_trial     = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge        = (sq_t >= sq_trial);
    assign sq_rem_step  = sq_ge ? 37'(sq_t - sq_trial) : 37'(sq_t);
    assign sq_root_step = {sq_root_reg[33:0], sq_ge};

    // restoring divide step: one quotient bit a cycle
    assign dv_t        = {dv_rem_reg, dv_num_reg[47]};
    assign dv_ge       = (dv_t >= {1'b0, dv_den_reg});
    assign dv_rem_step = dv_ge ? 35'(dv_t - {1'b0, dv_den_reg}) : 35'(dv_t);
    assign dv_quo_step = {dv_quo_reg[46:0], dv_ge};

    assign udiv_num = {mag_reg[axis_reg], 14'b0} + 47'(len_reg >> 1);

    assign cos_clamped  = (cos_next < -COS_LIMIT) ? -COS_LIMIT : cos_next;
    assign jct_root_arg = 30'(ONE_Q28 - cos_clamped);
    assign jct_den      = 29'(ONE_Q28) - s_reg;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL:
            begin
                if (step_reg < STEP_W'(AXES))
                begin
                    mul_a = mag_reg[idx_cur];
                    mul_b = mag_reg[idx_cur];
                end
                else if (step_reg == STEP_W'(AXES))
                begin
                    mul_a = {9'b0, feed_reg};
                    mul_b = {9'b0, feed_reg};
                end
                else
                begin
                    mul_a = {1'b0, accel_reg};
                    mul_b = {17'b0, dev_reg};
                end
            end
            ST_COS:
            begin
                if (step_reg < STEP_W'(AXES))
                begin
                    mul_a = {18'b0, last_abs[idx_cur]};
                    mul_b = {18'b0, unit_abs[idx_cur]};
                end
            end
            ST_AD_MUL:
            begin
                mul_a = (step_reg == '0) ? {9'b0, ad_reg[23:0]} : {9'b0, ad_reg[47:24]};
                mul_b = {4'b0, s_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        entry = jct_reg;
        if (nom_reg < entry)
            entry = nom_reg;
        if (last_nom_reg < entry)
            entry = last_nom_reg;
    end

    assign jct_final = (dv_quo_step < min_jct_reg) ? min_jct_reg : dv_quo_step;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        last_pos_next  = last_pos_reg;
        last_unit_next = last_unit_reg;
        last_nom_next  = last_nom_reg;
        head_next      = head_reg;
        tgt_next       = tgt_reg;
        mag_next       = mag_reg;
        dir_next       = dir_reg;
        unit_next      = unit_reg;
        feed_next      = feed_reg;
        empty_next     = empty_reg;
        sum_next       = sum_reg;
        nom_next       = nom_reg;
        ad_next        = ad_reg;
        len_next       = len_reg;
        cos_next       = cos_reg;
        s_next         = s_reg;
        big_next       = big_reg;
        jct_next       = jct_reg;
        sq_in_next     = sq_in_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        dv_rem_next    = dv_rem_reg;
        dv_den_next    = dv_den_reg;
        dv_num_next    = dv_num_reg;
        dv_quo_next    = dv_quo_reg;
        o_slot_next    = o_slot_reg;
        o_dir_next     = o_dir_reg;
        o_len_next     = o_len_reg;
        o_nom_next     = o_nom_reg;
        o_jct_next     = o_jct_reg;
        o_entry_next   = o_entry_reg;
        o_rest_next    = o_rest_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        tgt_next[i]  = in_tgt[i];
                        mag_next[i]  = delta[i][32] ? 33'(-delta[i]) : 33'(delta[i]);
                        dir_next[i]  = delta[i][32] ? DIR_NEG :
                                       (delta[i] != '0) ? DIR_POS : DIR_STOP;
                        unit_next[i] = '0;
                    end
                    feed_next  = feed;
                    empty_next = queue_empty;
                    sum_next   = '0;
                    cos_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end

            // squares of the deltas, feed rate squared, acceleration times deviation
            ST_MUL:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg != '0 && step_reg <= STEP_W'(AXES))
                    sum_next = sum_reg + prod_reg;
                else if (step_reg == STEP_W'(AXES + 1))
                    nom_next = prod_reg[47:0];
                else if (step_reg == STEP_W'(AXES + 2))
                begin
                    ad_next      = prod_reg[47:0];
                    sq_in_next   = {4'b0, sum_reg};
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    step_next    = '0;
                    state_next   = ST_LEN_SQRT;
                end
            end

            ST_LEN_SQRT:
            begin
                sq_in_next   = {sq_in_reg[67:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    len_next  = sq_root_step;
                    step_next = '0;
                    axis_next = '0;
                    // zero-length move keeps the cleared unit vector
                    state_next = (sq_root_step == '0) ? ST_COS : ST_UNIT_LOAD;
                end
            end

            ST_UNIT_LOAD:
            begin
                dv_rem_next = 35'(udiv_num >> 15);
                dv_num_next = {udiv_num[14:0], 33'b0};
                dv_den_next = len_reg;
                dv_quo_next = '0;
                step_next   = '0;
                state_next  = ST_UNIT_DIV;
            end

            // rounded |delta| * 2^14 / len, one quotient bit a cycle
            ST_UNIT_DIV:
            begin
                dv_rem_next = dv_rem_step;
                dv_num_next = {dv_num_reg[46:0], 1'b0};
                dv_quo_next = dv_quo_step;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(UDIV_STEPS - 1))
                begin
                    unit_next[axis_reg] = (dir_reg[axis_reg] == DIR_NEG) ?
                                          -$signed({1'b0, dv_quo_step[14:0]}) :
                                          $signed({1'b0, dv_quo_step[14:0]});
                    step_next = '0;
                    if (axis_reg == AXIS_W'(AXES - 1))
                        state_next = ST_COS;
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = ST_UNIT_LOAD;
                    end
                end
            end

            // cos = minus the dot product, sign-magnitude through the multiplier
            ST_COS:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg != '0)
                begin
                    if (last_unit_reg[idx_prev][15] ^ unit_reg[idx_prev][15])
                        cos_next = cos_reg + $signed({3'b0, prod_reg[28:0]});
                    else
                        cos_next = cos_reg - $signed({3'b0, prod_reg[28:0]});
                end
                if (step_reg == STEP_W'(AXES))
                begin
                    step_next = '0;
                    if (empty_reg)
                    begin
                        jct_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (cos_next >= COS_LIMIT)
                    begin
                        // near reversal
                        jct_next   = min_jct_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sq_in_next   = {13'b0, jct_root_arg, 27'b0};
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        state_next   = ST_JCT_SQRT;
                    end
                end
            end

            ST_JCT_SQRT:
            begin
                sq_in_next   = {sq_in_reg[67:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    s_next     = sq_root_step[28:0];
                    step_next  = '0;
                    state_next = ST_AD_MUL;
                end
            end

            // a*d*s in two partial products
            ST_AD_MUL:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(1))
                    big_next = {24'b0, prod_reg[52:0]};
                else if (step_reg == STEP_W'(2))
                begin
                    big_next  = big_reg + {prod_reg[52:0], 24'b0};
                    step_next = '0;
                    if (big_next[76:48] >= jct_den)
                    begin
                        jct_next   = MAX48;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dv_rem_next = {6'b0, big_next[76:48]};
                        dv_num_next = big_next[47:0];
                        dv_den_next = {6'b0, jct_den};
                        dv_quo_next = '0;
                        state_next  = ST_JCT_DIV;
                    end
                end
            end

            ST_JCT_DIV:
            begin
                dv_rem_next = dv_rem_step;
                dv_num_next = {dv_num_reg[46:0], 1'b0};
                dv_quo_next = dv_quo_step;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(JDIV_STEPS - 1))
                begin
                    jct_next   = jct_final;
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end

            // hand the beat to the output register and roll the history
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_slot_next    = 4'(head_reg);
                    o_dir_next     = dir_reg;
                    o_len_next     = len_reg[34] ? MAX34 : len_reg[33:0];
                    o_nom_next     = nom_reg;
                    o_jct_next     = (jct_reg < min_jct_reg && !empty_reg) ? min_jct_reg
                                                                           : jct_reg;
                    o_entry_next   = entry;
                    o_rest_next    = empty_reg;
                    last_pos_next  = tgt_reg;
                    last_unit_next = unit_reg;
                    last_nom_next  = nom_reg;
                    head_next      = (head_reg == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                           : head_reg + SLOT_W'(1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            last_nom_reg  <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            accel_reg     <= 32'd36000;
            dev_reg       <= 16'd655;
            min_jct_reg   <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                last_pos_reg[i]  <= '0;
                last_unit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            last_nom_reg  <= last_nom_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            last_pos_reg  <= last_pos_next;
            last_unit_reg <= last_unit_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACCEL:     accel_reg   <= cfg_data[31:0];
                    CFG_DEVIATION: dev_reg     <= cfg_data[15:0];
                    CFG_MIN_JCT:   min_jct_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg     <= tgt_next;
        mag_reg     <= mag_next;
        dir_reg     <= dir_next;
        unit_reg    <= unit_next;
        feed_reg    <= feed_next;
        empty_reg   <= empty_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        nom_reg     <= nom_next;
        ad_reg      <= ad_next;
        len_reg     <= len_next;
        cos_reg     <= cos_next;
        s_reg       <= s_next;
        big_reg     <= big_next;
        jct_reg     <= jct_next;
        sq_in_reg   <= sq_in_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_rem_reg  <= dv_rem_next;
        dv_den_reg  <= dv_den_next;
        dv_num_reg  <= dv_num_next;
        dv_quo_reg  <= dv_quo_next;
        o_slot_reg  <= o_slot_next;
        o_dir_reg   <= o_dir_next;
        o_len_reg   <= o_len_next;
        o_nom_reg   <= o_nom_next;
        o_jct_reg   <= o_jct_next;
        o_entry_reg <= o_entry_next;
        o_rest_reg  <= o_rest_next;
    end

    assign out_valid          = out_valid_reg;
    assign slot_index         = o_slot_reg;
    assign dir_x              = o_dir_reg[0];
    assign dir_y              = o_dir_reg[1];
    assign dir_z              = o_dir_reg[2];
    assign path_length        = o_len_reg;
    assign cruise_speed_sqr   = o_nom_reg;
    assign junction_speed_sqr = o_jct_reg;
    assign entry_limit_sqr    = o_entry_reg;
    assign start_from_rest    = o_rest_reg;

`ifndef SYNTHESIS
    // a finished beat always lands in the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished beat not presented");

    // entry speed never exceeds junction or nominal
    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_entry_reg <= o_jct_reg && o_entry_reg <= o_nom_reg))
        else $error("entry speed above a bound");

    // start from rest forces a zero junction limit
    a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_rest_reg) |-> (o_jct_reg == '0))
        else $error("junction limit set on an empty queue");

    // ring slot stays inside the ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= SLOT_W'(RING_DEPTH - 1))
        else $error("ring slot out of range");
`endif

endmodule

@@ verif/tb_junction_speed_planner.sv @@
// tb_junction_speed_planner: self-checking bench for the junction speed planner
// bit-exact predictor, queue-fed driver and monitor; depends on jsp_pkg and the rtl top
`timescale 1ns / 1ps

module tb_junction_speed_planner;

    import jsp_pkg::*;

    localparam int  ITEMS_PER_PHASE = 200;
    localparam int  CYCLE_LIMIT     = 3000000;
    localparam int  SETTLE_CYCLES   = 400;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [23:0]        feed;
        logic               empty;
    } move_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  dx;
        logic [1:0]  dy;
        logic [1:0]  dz;
        logic [33:0] len;
        logic [47:0] nominal;
        logic [47:0] junction;
        logic [47:0] entry;
        logic        rest;
    } plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] target_x = '0;
    logic signed [31:0] target_y = '0;
    logic signed [31:0] target_z = '0;
    logic [23:0]        feed = '0;
    logic               queue_empty = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         slot_index;
    logic [1:0]         dir_x;
    logic [1:0]         dir_y;
    logic [1:0]         dir_z;
    logic [33:0]        path_length;
    logic [47:0]        cruise_speed_sqr;
    logic [47:0]        junction_speed_sqr;
    logic [47:0]        entry_limit_sqr;
    logic               start_from_rest;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [47:0]        cfg_data = '0;

    junction_speed_planner u_dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .target_x            (target_x),
        .target_y            (target_y),
        .target_z            (target_z),
        .feed                (feed),
        .queue_empty         (queue_empty),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .slot_index          (slot_index),
        .dir_x               (dir_x),
        .dir_y               (dir_y),
        .dir_z               (dir_z),
        .path_length         (path_length),
        .cruise_speed_sqr    (cruise_speed_sqr),
        .junction_speed_sqr  (junction_speed_sqr),
        .entry_limit_sqr     (entry_limit_sqr),
        .start_from_rest     (start_from_rest),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // moves waiting to be driven, plans waiting to come out
    move_t move_queue[$];
    plan_t plan_queue[$];

    // planner history as the block should hold it
    longint      hist_pos[3];
    longint      hist_unit[3];
    logic [47:0] hist_nominal;
    logic [3:0]  hist_slot;

    // shadow of the configuration registers
    logic [31:0] accel_reg;
    logic [15:0] dev_reg;
    logic [47:0] min_jct_reg;

    int errors = 0;
    int moves_taken = 0;
    int plans_seen = 0;
    int rest_seen = 0;
    int reversal_seen = 0;
    longint cycles = 0;

    // floor square root, radicand below 2^70
    function automatic logic [34:0] floor_sqrt(logic [127:0] v);
        logic [34:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            c = {93'd0, r | (35'd1 << b)};
            if (c * c <= v)
                r = r | (35'd1 << b);
        end
        return r;
    endfunction

    // works out the plan for one move and advances the history
    function automatic plan_t plan_move(move_t m);
        plan_t        p;
        longint       tgt[3];
        longint       delta[3];
        longint       unit[3];
        logic [63:0]  mag;
        logic [127:0] sum;
        logic [127:0] wide_mag;
        logic [34:0]  len;
        logic [34:0]  sine;
        longint       cosv;
        logic [127:0] num;
        logic [127:0] quot;
        logic [63:0]  ad;
        logic [47:0]  jct;
        logic [47:0]  entry;
        logic [1:0]   dirs[3];

        tgt[0] = longint'(m.x);
        tgt[1] = longint'(m.y);
        tgt[2] = longint'(m.z);
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            delta[i] = tgt[i] - hist_pos[i];
            mag = (delta[i] < 0) ? -delta[i] : delta[i];
            wide_mag = {64'd0, mag};
            sum = sum + wide_mag * wide_mag;
            dirs[i] = (delta[i] > 0) ? DIR_POS : ((delta[i] < 0) ? DIR_NEG : DIR_STOP);
        end
        len = floor_sqrt(sum);

        // unit vector Q1.14, rounded half away from zero; zero length gives zero
        cosv = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                unit[i] = 0;
            else
            begin
                mag = (delta[i] < 0) ? -delta[i] : delta[i];
                unit[i] = longint'(((mag << 14) + {30'd0, len >> 1}) / {29'd0, len});
                if (delta[i] < 0)
                    unit[i] = -unit[i];
            end
            cosv = cosv - hist_unit[i] * unit[i];
        end

        if (m.empty)
            jct = '0;
        else if (cosv >= longint'(COS_LIMIT))
        begin
            jct = min_jct_reg;
            reversal_seen++;
        end
        else
        begin
            if (cosv < -longint'(COS_LIMIT))
                cosv = -longint'(COS_LIMIT);
            sine = floor_sqrt({64'd0, 64'(longint'(ONE_Q28) - cosv) << 27});
            ad = {32'd0, accel_reg} * {48'd0, dev_reg};
            num = {64'd0, ad} * {93'd0, sine};
            quot = num / (128'(longint'(ONE_Q28)) - {93'd0, sine});
            jct = (quot > {80'd0, MAX48}) ? MAX48 : quot[47:0];
            if (jct < min_jct_reg)
                jct = min_jct_reg;
        end

        p.nominal = {24'd0, m.feed} * {24'd0, m.feed};
        entry = jct;
        if (p.nominal < entry)
            entry = p.nominal;
        if (hist_nominal < entry)
            entry = hist_nominal;

        p.slot     = hist_slot;
        p.dx       = dirs[0];
        p.dy       = dirs[1];
        p.dz       = dirs[2];
        p.len      = (len > {1'b0, MAX34}) ? MAX34 : len[33:0];
        p.junction = jct;
        p.entry    = entry;
        p.rest     = m.empty;

        for (int i = 0; i < 3; i++)
        begin
            hist_pos[i]  = tgt[i];
            hist_unit[i] = unit[i];
        end
        hist_nominal = p.nominal;
        hist_slot    = (hist_slot == RING_DEPTH - 1) ? 4'd0 : hist_slot + 4'd1;
        return p;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        move_t nxt;
        logic  busy;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                plan_queue.push_back(plan_move({target_x, target_y, target_z,
                                                feed, queue_empty}));
                moves_taken++;
            end
            // hold the beat until it is taken
            busy = in_valid && !in_ready;
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (move_queue.size() != 0)
                begin
                    nxt = move_queue.pop_front();
                    in_valid    <= 1'b1;
                    target_x    <= nxt.x;
                    target_y    <= nxt.y;
                    target_z    <= nxt.z;
                    feed        <= nxt.feed;
                    queue_empty <= nxt.empty;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        // often no gap at all, otherwise long enough to land anywhere
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 260);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between free-running and random stalls
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk)
    begin
        plan_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                plans_seen++;
                if (plan_queue.size() == 0)
                begin
                    $error("result beat with no plan waiting");
                    errors++;
                end
                else
                begin
                    want = plan_queue.pop_front();
                    if (start_from_rest)
                        rest_seen++;
                    if (slot_index !== want.slot)
                    begin
                        $error("slot_index exp %0d got %0d", want.slot, slot_index);
                        errors++;
                    end
                    if (dir_x !== want.dx)
                    begin
                        $error("dir_x exp %0d got %0d", want.dx, dir_x);
                        errors++;
                    end
                    if (dir_y !== want.dy)
                    begin
                        $error("dir_y exp %0d got %0d", want.dy, dir_y);
                        errors++;
                    end
                    if (dir_z !== want.dz)
                    begin
                        $error("dir_z exp %0d got %0d", want.dz, dir_z);
                        errors++;
                    end
                    if (path_length !== want.len)
                    begin
                        $error("path_length exp %0d got %0d", want.len, path_length);
                        errors++;
                    end
                    if (cruise_speed_sqr !== want.nominal)
                    begin
                        $error("cruise_speed_sqr exp %0d got %0d",
                               want.nominal, cruise_speed_sqr);
                        errors++;
                    end
                    if (junction_speed_sqr !== want.junction)
                    begin
                        $error("junction_speed_sqr exp %0d got %0d",
                               want.junction, junction_speed_sqr);
                        errors++;
                    end
                    if (entry_limit_sqr !== want.entry)
                    begin
                        $error("entry_limit_sqr exp %0d got %0d",
                               want.entry, entry_limit_sqr);
                        errors++;
                    end
                    if (start_from_rest !== want.rest)
                    begin
                        $error("start_from_rest exp %0d got %0d", want.rest, start_from_rest);
                        errors++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 600);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ACCEL:     accel_reg   = val[31:0];
            CFG_DEVIATION: dev_reg     = val[15:0];
            CFG_MIN_JCT:   min_jct_reg = val;
            default:       ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender pauses here until every plan has come out
    task automatic drain;
        while (move_queue.size() != 0 || in_valid || plan_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus side keeps its own idea of the last target to shape moves
    logic signed [31:0] gen_pos[3];
    logic signed [31:0] gen_prev[3];

    task automatic add_move(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic [23:0] f, logic e);
        move_t m;
        m.x = x;
        m.y = y;
        m.z = z;
        m.feed = f;
        m.empty = e;
        move_queue.push_back(m);
        gen_prev = gen_pos;
        gen_pos[0] = x;
        gen_pos[1] = y;
        gen_pos[2] = z;
    endtask

    function automatic logic signed [31:0] nudge(logic signed [31:0] v, int span);
        return v + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_random_move;
        logic signed [31:0] t[3];
        logic signed [31:0] d[3];
        logic [23:0]        f;
        logic               e;
        int                 kind;
        int                 span;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) == 0) ? 4096 : 1 << $urandom_range(12, 24);
        for (int i = 0; i < 3; i++)
            d[i] = gen_pos[i] - gen_prev[i];
        case (kind)
            0:       t = gen_pos;                                    // zero length
            1:       t = gen_prev;                                   // reversal
            2:       for (int i = 0; i < 3; i++) t[i] = gen_pos[i] + d[i]; // straight on
            3:       for (int i = 0; i < 3; i++) t[i] = $urandom;    // anywhere
            4:       for (int i = 0; i < 3; i++) t[i] = gen_pos[i] - d[i] + nudge(0, 64);
            default: for (int i = 0; i < 3; i++)
                         t[i] = ($urandom_range(0, 3) == 0) ? gen_pos[i] : nudge(gen_pos[i], span);
        endcase
        case ($urandom_range(0, 4))
            0:       f = 24'($urandom);
            1:       f = 24'($urandom_range(0, 255));
            2:       f = 24'hFFFFFF - 24'($urandom_range(0, 255));
            default: f = 24'($urandom_range(0, 60000 * 256));
        endcase
        e = ($urandom_range(0, 9) == 0);
        add_move(t[0], t[1], t[2], f, e);
    endtask

    task automatic add_random_phase;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            add_random_move();
    endtask

    initial
    begin
        hist_pos     = '{0, 0, 0};
        hist_unit    = '{0, 0, 0};
        hist_nominal = '0;
        hist_slot    = '0;
        accel_reg    = 32'd36000;
        dev_reg      = 16'd655;
        min_jct_reg  = '0;
        gen_pos      = '{0, 0, 0};
        gen_prev     = '{0, 0, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed moves under reset settings
        add_move(0, 0, 0, 24'd0, 1'b1);                         // zero length from rest
        add_move(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF, 1'b0);
        add_move(32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hFFFFFF, 1'b0); // reversal
        add_move(32'sh80000000, 32'sh80000000, 32'sh80000000, 24'd1, 1'b0);      // stand still
        add_move(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 24'd3000, 1'b0);
        add_move(0, 0, 0, 24'd12800, 1'b0);
        add_move(32'sd65536, 0, 0, 24'd12800, 1'b0);
        add_move(32'sd131072, 0, 0, 24'd12800, 1'b0);           // straight line
        add_move(32'sd131072, 32'sd65536, 0, 24'd12800, 1'b0);  // right angle
        add_move(32'sd131072, 32'sd65536, 0, 24'd12800, 1'b1);  // zero length, empty queue
        add_move(32'sd65536, 0, 32'sd1, 24'd256, 1'b0);
        add_move(32'sd131072, 32'sd65536, 0, 24'd256, 1'b0);    // near reversal
        add_move(32'sd131073, 32'sd65537, 32'sd1, 24'd77, 1'b0); // tiny step
        add_move(-32'sd1, -32'sd1, -32'sd1, 24'hFFFFFF, 1'b1);
        for (int n = 0; n < 8; n++)
            add_move(-32'sd1 - n * 32'sd100000, 32'sd5 * n, -32'sd1, 24'd50000, 1'b0);
        drain();
        add_random_phase();
        drain();

        // extremes of acceleration and deviation
        write_reg(CFG_ACCEL, 48'hFFFFFFFF);
        write_reg(CFG_DEVIATION, 48'hFFFF);
        write_reg(CFG_MIN_JCT, 48'd0);
        add_random_phase();
        drain();

        write_reg(CFG_ACCEL, 48'd0);
        write_reg(CFG_MIN_JCT, 48'd1 << $urandom_range(0, 47));
        add_random_phase();
        drain();

        write_reg(CFG_ACCEL, {16'd0, 32'($urandom)});
        write_reg(CFG_DEVIATION, 48'd0);
        write_reg(CFG_MIN_JCT, {48{1'b1}});
        add_random_phase();
        drain();

        write_reg(CFG_ACCEL, 48'd36000);
        write_reg(CFG_DEVIATION, {32'd0, 16'($urandom)});
        write_reg(CFG_MIN_JCT, {16'($urandom), 32'($urandom)});
        add_random_phase();
        drain();

        write_reg(CFG_ACCEL, 48'd1);
        write_reg(CFG_DEVIATION, 48'd1);
        write_reg(CFG_MIN_JCT, {32'd0, 16'($urandom)});
        add_random_phase();
        drain();

        $display("moves taken %0d, plans checked %0d, from rest %0d, reversals %0d",
                 moves_taken, plans_seen, rest_seen, reversal_seen);
        $display("six register settings incl. extremes, %0d cycles", cycles);
        if (errors == 0 && plan_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
